### rtl/obj_text_tokenizer_assert.svh
// assertion macros for the obj text tokenizer
`ifndef OBJ_TEXT_TOKENIZER_ASSERT_SVH
`define OBJ_TEXT_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define OTT_ASSERT_NOW(lbl, clk, rst_n, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// next-cycle implication
`define OTT_ASSERT_NEXT(lbl, clk, rst_n, cond, conseq, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### rtl/ott_pkg.sv
// types, constants and character classes of the obj text tokenizer
`timescale 1ns / 1ps
`default_nettype none

package ott_pkg;

    localparam int OTT_OFFSET_BITS = 24;
    localparam int OTT_LINE_BITS   = 24;
    localparam int OTT_FIELD_W     = 24;
    localparam int OTT_QUEUE_DEPTH = 4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_N     = 8'h6e;
    localparam logic [7:0] CH_O     = 8'h6f;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_NUM_FIRST,
        MODE_NUM_INT,
        MODE_NUM_FRAC,
        MODE_EXP_SIGN,
        MODE_EXP_DIG
    } t_mode;

    typedef enum logic [3:0] {
        KIND_POSITION = 4'd0,
        KIND_TEXCOORD = 4'd1,
        KIND_NORMAL   = 4'd2,
        KIND_FACE     = 4'd3,
        KIND_GROUP    = 4'd4,
        KIND_OBJECT   = 4'd5,
        KIND_SMOOTH   = 4'd6,
        KIND_IDENT    = 4'd7,
        KIND_NUMBER   = 4'd8,
        KIND_SLASH    = 4'd9,
        KIND_COMMENT  = 4'd10,
        KIND_NEWLINE  = 4'd11,
        KIND_END      = 4'd12,
        KIND_ERROR    = 4'd13
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [OTT_FIELD_W-1:0] offset;
        logic [OTT_FIELD_W-1:0] length;
        logic [OTT_FIELD_W-1:0] line;
        logic                   last;
    } t_token;

    function automatic logic ott_is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic ott_is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == 8'h5f);
    endfunction

endpackage

`default_nettype wire

### rtl/obj_text_tokenizer.sv
// streaming lexer for obj text, one byte in, up to two tokens out
`timescale 1ns / 1ps
`default_nettype none
`include "obj_text_tokenizer_assert.svh"

// Takes one text byte per cycle on the slave stream and emits tokens (kind on
// tuser, offset/length/line on tdata, tlast on the last token of a byte). A
// byte is classified and the lexer state updated in the cycle it is accepted;
// its tokens go into a four-entry token queue that feeds the master stream.
// s_axis_tready is high while the queue has two free entries, so bytes flow
// at one per cycle as long as the sink keeps up; a byte that closes a pending
// token and also forms its own gives two tokens.
// Byte 0 emits the end token and returns all lexer state to its reset value.
module obj_text_tokenizer
    import ott_pkg::*;
#(
    parameter int OFFSET_BITS = OTT_OFFSET_BITS,
    parameter int LINE_BITS   = OTT_LINE_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // text_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // token_offset, token_length, token_line
    output logic [3:0]       m_axis_tuser,   // token_kind
    output logic             m_axis_tlast    // run_last
);

    localparam int PTR_W = $clog2(OTT_QUEUE_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [LINE_BITS-1:0]   r_pline, n_pline;
    logic [7:0]             r_first, n_first;
    logic [7:0]             r_second, n_second;

    t_token                 r_queue [OTT_QUEUE_DEPTH];
    logic [PTR_W-1:0]       r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]       r_count;

    logic [7:0]             c;
    logic                   w_in_acc, w_pop;
    logic                   w_dig, w_alpha;
    logic                   w_ext, w_pend, w_flush, w_fresh, w_fresh_emit, w_start_tok;
    logic                   w_skip, w_end, w_slash, w_lf, w_hash, w_numstart, w_error;
    t_mode                  w_ext_mode;
    logic [OFFSET_BITS-1:0] w_len;
    t_kind                  w_flush_kind;
    t_token                 w_tok_flush, w_tok_fresh, w_entry0, w_entry1;
    logic [1:0]             w_push_n;

    assign c        = s_axis_tdata;
    assign w_dig    = ott_is_digit(c);
    assign w_alpha  = ott_is_alpha(c);
    assign w_len    = r_pos - r_start;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_pop    = m_axis_tvalid && m_axis_tready;

    // continuation of the pending token
    always_comb begin
        w_ext      = 1'b0;
        w_ext_mode = r_mode;
        unique case (r_mode)
            MODE_IDLE: begin
                w_ext = 1'b0;
            end
            MODE_COMMENT: begin
                w_ext = (c != CH_NUL) && (c != CH_LF);
            end
            MODE_IDENT: begin
                w_ext = w_alpha || w_dig;
            end
            MODE_NUM_FIRST: begin
                priority if (c == CH_MINUS || w_dig) begin
                    w_ext = 1'b1;
                    w_ext_mode = MODE_NUM_INT;
                end else if (c == CH_DOT) begin
                    w_ext = 1'b1;
                    w_ext_mode = MODE_NUM_FRAC;
                end else if (c == CH_LO_E || c == CH_UP_E) begin
                    w_ext = 1'b1;
                    w_ext_mode = MODE_EXP_SIGN;
                end else begin
                    w_ext = 1'b0;
                end
            end
            MODE_NUM_INT: begin
                priority if (w_dig) begin
                    w_ext = 1'b1;
                end else if (c == CH_DOT) begin
                    w_ext = 1'b1;
                    w_ext_mode = MODE_NUM_FRAC;
                end else if (c == CH_LO_E || c == CH_UP_E) begin
                    w_ext = 1'b1;
                    w_ext_mode = MODE_EXP_SIGN;
                end else begin
                    w_ext = 1'b0;
                end
            end
            MODE_NUM_FRAC: begin
                priority if (w_dig) begin
                    w_ext = 1'b1;
                end else if (c == CH_LO_E || c == CH_UP_E) begin
                    w_ext = 1'b1;
                    w_ext_mode = MODE_EXP_SIGN;
                end else begin
                    w_ext = 1'b0;
                end
            end
            MODE_EXP_SIGN: begin
                if (c == CH_MINUS || c == CH_PLUS || w_dig) begin
                    w_ext = 1'b1;
                    w_ext_mode = MODE_EXP_DIG;
                end
            end
            MODE_EXP_DIG: begin
                w_ext = w_dig;
            end
        endcase
    end

    assign w_pend      = (r_mode != MODE_IDLE);
    assign w_flush     = w_pend && !w_ext;
    assign w_fresh     = !(w_pend && w_ext);
    assign w_skip      = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
    assign w_end       = (c == CH_NUL);
    assign w_slash     = (c == CH_SLASH);
    assign w_lf        = (c == CH_LF);
    assign w_hash      = (c == CH_HASH);
    assign w_numstart  = (c == CH_MINUS) || w_dig;
    assign w_start_tok = w_fresh && (w_hash || w_alpha || w_numstart);
    assign w_error     = !w_skip && !w_end && !w_slash && !w_lf && !w_hash && !w_alpha
                         && !w_numstart;
    assign w_fresh_emit = w_fresh && (w_end || w_slash || w_lf || w_error);

    // kind of the token being closed
    always_comb begin
        w_flush_kind = KIND_NUMBER;
        priority if (r_mode == MODE_COMMENT) begin
            w_flush_kind = KIND_COMMENT;
        end else if (r_mode == MODE_IDENT) begin
            w_flush_kind = KIND_IDENT;
            priority if (w_len == OFFSET_BITS'(1)) begin
                priority if (r_first == CH_F) begin
                    w_flush_kind = KIND_FACE;
                end else if (r_first == CH_G) begin
                    w_flush_kind = KIND_GROUP;
                end else if (r_first == CH_O) begin
                    w_flush_kind = KIND_OBJECT;
                end else if (r_first == CH_S) begin
                    w_flush_kind = KIND_SMOOTH;
                end else if (r_first == CH_V) begin
                    w_flush_kind = KIND_POSITION;
                end else begin
                    w_flush_kind = KIND_IDENT;
                end
            end else if (w_len == OFFSET_BITS'(2) && r_first == CH_V) begin
                priority if (r_second == CH_T) begin
                    w_flush_kind = KIND_TEXCOORD;
                end else if (r_second == CH_N) begin
                    w_flush_kind = KIND_NORMAL;
                end else begin
                    w_flush_kind = KIND_IDENT;
                end
            end else begin
                w_flush_kind = KIND_IDENT;
            end
        end else begin
            w_flush_kind = KIND_NUMBER;
        end
    end

    // token records and queue entries
    always_comb begin
        w_tok_flush.kind   = w_flush_kind;
        w_tok_flush.offset = OTT_FIELD_W'(32'(r_start));
        w_tok_flush.length = OTT_FIELD_W'(32'(w_len));
        w_tok_flush.line   = OTT_FIELD_W'(32'(r_pline));
        w_tok_flush.last   = 1'b0;

        w_tok_fresh.offset = OTT_FIELD_W'(32'(r_pos));
        w_tok_fresh.line   = OTT_FIELD_W'(32'(r_line));
        w_tok_fresh.last   = 1'b1;
        w_tok_fresh.length = OTT_FIELD_W'(1);
        priority if (w_end) begin
            w_tok_fresh.kind   = KIND_END;
            w_tok_fresh.length = '0;
        end else if (w_slash) begin
            w_tok_fresh.kind = KIND_SLASH;
        end else if (w_lf) begin
            w_tok_fresh.kind = KIND_NEWLINE;
        end else begin
            w_tok_fresh.kind = KIND_ERROR;
        end

        w_push_n = 2'(w_flush) + 2'(w_fresh_emit);
        w_entry1 = w_tok_fresh;
        if (w_flush) begin
            w_entry0      = w_tok_flush;
            w_entry0.last = !w_fresh_emit;
        end else begin
            w_entry0 = w_tok_fresh;
        end
    end

    // next lexer state
    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_start  = r_start;
        n_line   = r_line;
        n_pline  = r_pline;
        n_first  = r_first;
        n_second = r_second;
        if (w_in_acc) begin
            if (w_pend && w_ext) begin
                n_mode = w_ext_mode;
                if (r_mode == MODE_IDENT && w_len == OFFSET_BITS'(1)) begin
                    n_second = c;
                end
            end else begin
                n_mode = MODE_IDLE;
                if (w_lf && r_line != '1) begin
                    n_line = r_line + LINE_BITS'(1);
                end
                if (w_start_tok) begin
                    n_start = r_pos;
                    n_pline = r_line;
                    priority if (w_hash) begin
                        n_mode = MODE_COMMENT;
                    end else if (w_alpha) begin
                        n_mode   = MODE_IDENT;
                        n_first  = c;
                        n_second = '0;
                    end else begin
                        n_mode = MODE_NUM_FIRST;
                    end
                end
            end
            if (w_fresh && w_end) begin
                n_mode   = MODE_IDLE;
                n_pos    = '0;
                n_start  = '0;
                n_line   = '0;
                n_pline  = '0;
                n_first  = '0;
                n_second = '0;
            end else if (r_pos != '1) begin
                n_pos = r_pos + OFFSET_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_line   <= '0;
            r_pline  <= '0;
            r_first  <= '0;
            r_second <= '0;
        end else begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_line   <= n_line;
            r_pline  <= n_pline;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    // token queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_in_acc) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(w_push_n);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (w_in_acc ? CNT_W'(w_push_n) : CNT_W'(0))
                       - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_push_n != 2'd0) begin
            r_queue[r_wr_ptr] <= w_entry0;
        end
        if (w_in_acc && w_push_n == 2'd2) begin
            r_queue[r_wr_ptr + PTR_W'(1)] <= w_entry1;
        end
    end

    assign s_axis_tready = (r_count <= CNT_W'(OTT_QUEUE_DEPTH - 2));
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {r_queue[r_rd_ptr].line, r_queue[r_rd_ptr].length,
                            r_queue[r_rd_ptr].offset};
    assign m_axis_tuser  = r_queue[r_rd_ptr].kind;
    assign m_axis_tlast  = r_queue[r_rd_ptr].last;

    `OTT_ASSERT_NOW(a_room_for_two, i_clk, i_rst_n, w_in_acc, r_count <= CNT_W'(2), "byte taken without room for two tokens")
    `OTT_ASSERT_NOW(a_two_needs_close, i_clk, i_rst_n, w_in_acc && w_push_n == 2'd2, w_flush, "two tokens without a closed pending token")
    `OTT_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, w_in_acc && s_axis_tdata == CH_NUL, r_pos == '0 && r_line == '0 && r_mode == MODE_IDLE, "end of text did not clear lexer state")
    `OTT_ASSERT_NEXT(a_push_shows, i_clk, i_rst_n, w_in_acc && w_push_n != 2'd0, m_axis_tvalid, "queued token not presented")

endmodule

`default_nettype wire
